// File: src/tpl_pkg.sv
// ----------------------------------------------------------------------------
// tpl_pkg
// Shared types, codes and default constants of the tabu pair list.
// ----------------------------------------------------------------------------
package tpl_pkg;

  localparam int N_DEF       = 64;
  localparam int MAX_LEN_DEF = 32;
  localparam int MIN_LEN_DEF = 4;
  localparam int STEP_DEF    = 1;

  localparam int IDX_W     = 6;
  localparam int NL_W      = 8;
  localparam int COEF_W    = 16;
  localparam int CUT_W     = 15;
  localparam int LEN_OUT_W = 6;
  localparam int CFG_AW    = 1;
  localparam int IN_DW     = 24;
  localparam int IN_UW     = 4;
  localparam int OUT_DW    = 8;

  localparam logic [CUT_W-1:0] CUTOFF_RST = 15'd26;

  typedef enum logic [2:0] {
    OP_CHECK  = 3'd0,
    OP_ADD    = 3'd1,
    OP_GROW   = 3'd2,
    OP_SHRINK = 3'd3,
    OP_RESIZE = 3'd4,
    OP_CLEAR  = 3'd5
  } opcode_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_COEF   = 1'b0,
    CFG_CUTOFF = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SET,
    S_SWEEP,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [3:0]       pad;
    logic [NL_W-1:0]  new_length;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
  } in_data_t;

  typedef struct packed {
    logic    move_valid;
    opcode_t opcode;
  } in_user_t;

  typedef struct packed {
    logic [LEN_OUT_W-1:0] length_now;
    logic                 stored;
    logic                 tabu_hit;
  } result_t;

endpackage

// File: src/tpl_ram.sv
// ----------------------------------------------------------------------------
// tpl_ram
// Simple dual-port synchronous memory with one write port and one
// registered read port.
// ----------------------------------------------------------------------------
module tpl_ram #(
  parameter int DW    = 1,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/tabu_pair_list.sv
// A check or an add is answered from the EXEC state, or from the SET state when an older pair is
// evicted, since the bit table has a single write port; a busy output holds the result in RESP.
// A length change or a clear adds a sweep over all RING_DEPTH entries of the ring memory.
// One beat is worked on at a time; the next is taken while a result still waits on the output.
// Reset is synchronous; afterwards every entry of the bit table is cleared before in_tready rises.
// ----------------------------------------------------------------------------
// tabu_pair_list
// Ring of recent moves in a ring memory plus an N-by-N tabu bit table,
// with check, add, grow, shrink, resize and clear operations.
// ----------------------------------------------------------------------------
module tabu_pair_list
  import tpl_pkg::*;
#(
  parameter int N       = N_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF,
  parameter int MIN_LEN = MIN_LEN_DEF,
  parameter int STEP    = STEP_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // row, col, new_length, zero pad
  input  logic [IN_UW-1:0]  in_tuser,   // opcode, move_valid
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // tabu_hit, stored, length_now
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [COEF_W-1:0] cfg_wdata
);

  localparam int RING_DEPTH = (MAX_LEN > MIN_LEN) ? MAX_LEN : MIN_LEN;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEN_W      = $clog2(RING_DEPTH + 1);
  localparam int CALC_W     = $clog2(RING_DEPTH + STEP + (1 << NL_W)) + 1;
  localparam int TBL_DEPTH  = N * N;
  localparam int TBL_AW     = $clog2(TBL_DEPTH);
  localparam int PAIR_W     = 2 * IDX_W;

  in_data_t in_d;
  in_user_t in_u;
  logic     accept;
  logic     out_free;

  state_t state_r, state_nxt;

  logic signed [COEF_W-1:0] coef_r;
  logic [CUT_W-1:0]         cut_r;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [RING_AW-1:0]       pos_r, pos_nxt;
  logic [RING_DEPTH-1:0]    valid_r, valid_nxt;
  logic [TBL_AW-1:0]        init_cnt_r, init_cnt_nxt;
  logic [LEN_W-1:0]         sw_cnt_r, sw_cnt_nxt;
  logic                     sw_pend_r, sw_pend_nxt;
  logic                     out_valid_r, out_valid_nxt;
  result_t                  out_data_r, out_data_nxt;
  result_t                  res_r, res_nxt;

  opcode_t          op_r;
  logic             mv_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_r;
  logic [NL_W-1:0]  nl_r;

  logic              ring_we;
  logic [RING_AW-1:0] ring_waddr;
  logic [PAIR_W-1:0] ring_wdata;
  logic [RING_AW-1:0] ring_raddr;
  logic [PAIR_W-1:0] ring_rdata;
  logic              tbl_we;
  logic [TBL_AW-1:0] tbl_waddr;
  logic              tbl_wdata;
  logic [TBL_AW-1:0] tbl_raddr;
  logic              tbl_rdata;

  logic                     move_ok;
  logic signed [COEF_W:0]   coef_x;
  logic signed [COEF_W:0]   cut_x;
  logic                     coef_low;
  logic                     add_ok;
  logic [TBL_AW-1:0]        new_addr;
  logic [TBL_AW-1:0]        old_addr;
  logic [TBL_AW-1:0]        in_addr;
  logic                     old_valid;
  logic [LEN_W-1:0]         pos_inc;
  logic                     pos_wrap;
  logic signed [CALC_W-1:0] len_x;
  logic signed [CALC_W-1:0] req;
  logic signed [CALC_W-1:0] clamp;
  logic [LEN_W-1:0]         len_clamped;
  logic                     len_change;
  logic [RING_AW-1:0]       sw_idx;
  logic                     sw_reading;
  logic                     sw_last;
  logic                     exec_to_set;
  logic                     exec_to_sweep;
  logic                     done;

  assign in_d      = in_data_t'(in_tdata);
  assign in_u      = in_user_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  tpl_ram #(
    .DW    (PAIR_W),
    .DEPTH (RING_DEPTH),
    .AW    (RING_AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (ring_waddr),
    .wr_data (ring_wdata),
    .rd_addr (ring_raddr),
    .rd_data (ring_rdata)
  );

  tpl_ram #(
    .DW    (1),
    .DEPTH (TBL_DEPTH),
    .AW    (TBL_AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  assign move_ok  = mv_r && (32'(row_r) < N) && (32'(col_r) < N);
  assign coef_x   = {coef_r[COEF_W-1], coef_r};
  assign cut_x    = signed'({2'b00, cut_r});
  assign coef_low = (coef_x < cut_x) && (coef_x > -cut_x);
  assign add_ok   = (coef_x >= cut_x) && move_ok;
  assign new_addr = TBL_AW'(32'(row_r) * N + 32'(col_r));
  assign old_addr = TBL_AW'(32'(ring_rdata[PAIR_W-1:IDX_W]) * N + 32'(ring_rdata[IDX_W-1:0]));
  assign in_addr  = TBL_AW'(32'(in_d.row) * N + 32'(in_d.col));
  assign old_valid = valid_r[pos_r];
  assign pos_inc  = LEN_W'(pos_r) + LEN_W'(1);
  assign pos_wrap = (pos_inc == len_r);

  always_comb begin
    len_x = signed'(CALC_W'(len_r));
    case (op_r)
      OP_GROW:   req = len_x + signed'(CALC_W'(STEP));
      OP_SHRINK: req = len_x - signed'(CALC_W'(STEP));
      OP_RESIZE: req = signed'(CALC_W'(nl_r));
      default:   req = len_x;
    endcase
    clamp = req;
    if (clamp < signed'(CALC_W'(MIN_LEN))) begin
      clamp = signed'(CALC_W'(MIN_LEN));
    end
    if (clamp > signed'(CALC_W'(MAX_LEN))) begin
      clamp = signed'(CALC_W'(MAX_LEN));
    end
  end

  assign len_clamped = LEN_W'(clamp);
  assign len_change  = (len_clamped != len_r);

  assign sw_idx     = sw_cnt_r[RING_AW-1:0];
  assign sw_reading = (sw_cnt_r < LEN_W'(RING_DEPTH));
  assign sw_last    = (sw_cnt_r == LEN_W'(RING_DEPTH));

  assign exec_to_set   = (op_r == OP_ADD) && add_ok && old_valid;
  assign exec_to_sweep = (op_r == OP_CLEAR) ||
                         (((op_r == OP_GROW) || (op_r == OP_SHRINK) || (op_r == OP_RESIZE))
                          && len_change);
  assign done = ((state_r == S_EXEC) && !exec_to_set && !exec_to_sweep) ||
                (state_r == S_SET) || ((state_r == S_SWEEP) && sw_last) ||
                (state_r == S_RESP);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (init_cnt_r == TBL_AW'(TBL_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_to_set) begin
          state_nxt = S_SET;
        end else if (exec_to_sweep) begin
          state_nxt = S_SWEEP;
        end
      end
      S_SET, S_SWEEP, S_RESP: begin
        state_nxt = state_r;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
    if (done) begin
      state_nxt = out_free ? S_IDLE : S_RESP;
    end
  end

  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    valid_nxt     = valid_r;
    res_nxt       = res_r;
    init_cnt_nxt  = init_cnt_r;
    sw_cnt_nxt    = sw_cnt_r;
    sw_pend_nxt   = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ring_we       = 1'b0;
    ring_waddr    = pos_r;
    ring_wdata    = {row_r, col_r};
    ring_raddr    = pos_r;
    tbl_we        = 1'b0;
    tbl_waddr     = new_addr;
    tbl_wdata     = 1'b0;
    tbl_raddr     = in_addr;
    case (state_r)
      S_INIT: begin
        tbl_we       = 1'b1;
        tbl_waddr    = init_cnt_r;
        init_cnt_nxt = init_cnt_r + TBL_AW'(1);
      end
      S_EXEC: begin
        res_nxt.tabu_hit = 1'b0;
        res_nxt.stored   = 1'b0;
        case (op_r)
          OP_CHECK: begin
            res_nxt.tabu_hit = !coef_low && move_ok && tbl_rdata;
          end
          OP_ADD: begin
            if (add_ok) begin
              ring_we          = 1'b1;
              valid_nxt[pos_r] = 1'b1;
              tbl_we           = 1'b1;
              if (old_valid) begin
                tbl_waddr = old_addr;
                tbl_wdata = 1'b0;
              end else begin
                tbl_wdata = 1'b1;
              end
              pos_nxt        = pos_wrap ? '0 : pos_r + RING_AW'(1);
              res_nxt.stored = 1'b1;
            end
          end
          OP_GROW, OP_SHRINK, OP_RESIZE: begin
            if (len_change) begin
              len_nxt    = len_clamped;
              pos_nxt    = '0;
              sw_cnt_nxt = '0;
            end
          end
          OP_CLEAR: begin
            len_nxt    = LEN_W'(MIN_LEN);
            pos_nxt    = '0;
            sw_cnt_nxt = '0;
          end
          default: begin
            res_nxt.stored = 1'b0;
          end
        endcase
        res_nxt.length_now = LEN_OUT_W'(len_nxt);
      end
      S_SET: begin
        tbl_we    = 1'b1;
        tbl_wdata = 1'b1;
      end
      S_SWEEP: begin
        ring_raddr  = sw_idx;
        sw_pend_nxt = sw_reading && valid_r[sw_idx];
        if (sw_pend_r) begin
          tbl_we    = 1'b1;
          tbl_waddr = old_addr;
          tbl_wdata = 1'b0;
        end
        if (sw_last) begin
          valid_nxt = '0;
        end else begin
          sw_cnt_nxt = sw_cnt_r + LEN_W'(1);
        end
      end
      default: begin
        sw_pend_nxt = 1'b0;
      end
    endcase
    if (done && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      len_r       <= LEN_W'(MIN_LEN);
      pos_r       <= '0;
      valid_r     <= '0;
      init_cnt_r  <= '0;
      sw_cnt_r    <= '0;
      sw_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      coef_r      <= '0;
      cut_r       <= CUTOFF_RST;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      valid_r     <= valid_nxt;
      init_cnt_r  <= init_cnt_nxt;
      sw_cnt_r    <= sw_cnt_nxt;
      sw_pend_r   <= sw_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_COEF:   coef_r <= signed'(cfg_wdata);
          CFG_CUTOFF: cut_r  <= cfg_wdata[CUT_W-1:0];
          default:    cut_r  <= cut_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_u.opcode;
      mv_r  <= in_u.move_valid;
      row_r <= in_d.row;
      col_r <= in_d.col;
      nl_r  <= in_d.new_length;
    end
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    LEN_W'(pos_r) < len_r)
    else $error("ring position not below ring length");

  a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) && (len_r <= LEN_W'(RING_DEPTH)))
    else $error("ring length out of range");

  a_sweep_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) && sw_last |=> (valid_r == '0))
    else $error("ring entries left valid after sweep");

  a_set_after_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SET) |-> $past((state_r == S_EXEC) && (op_r == OP_ADD)))
    else $error("table set step without an add");

  a_tbl_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> (state_r != S_IDLE) && (state_r != S_RESP))
    else $error("table written while idle");

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the tabu pair list.
// A scoreboard class tracks the ring, the bit table, the length and both
// registers. It predicts one result for every accepted input beat and
// compares the result beats field by field. A directed sequence comes
// first. Random traffic then runs under twelve register settings, with
// bursty input, a receiver that stalls on its own pattern, and one long
// output hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb
  import tpl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH  = (MAX_LEN_DEF > MIN_LEN_DEF) ? MAX_LEN_DEF : MIN_LEN_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BEATS = 90;
  localparam int NUM_SETS    = 12;
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;

  // The scoreboard keeps its own copy of the ring, the bit table, the length and the registers.
  class tabu_scoreboard;
    logic signed [COEF_W-1:0] coef;
    logic [CUT_W-1:0]         cutoff;
    bit                       ring_vld [RING_DEPTH];
    logic [IDX_W-1:0]         ring_row [RING_DEPTH];
    logic [IDX_W-1:0]         ring_col [RING_DEPTH];
    bit                       tabu_map [N_DEF*N_DEF];
    int unsigned              pos;
    int unsigned              len;
    result_t                  expected_q[$];
    int                       errors;

    function new();
      coef   = '0;
      cutoff = CUTOFF_RST;
      errors = 0;
      len    = MIN_LEN_DEF;
      wipe();
    endfunction

    function void wipe();
      foreach (ring_vld[i]) ring_vld[i] = 1'b0;
      foreach (tabu_map[i]) tabu_map[i] = 1'b0;
      pos = 0;
    endfunction

    function void set_length(int req);
      int l;
      l = req;
      if (l < MIN_LEN_DEF) l = MIN_LEN_DEF;
      if (l > MAX_LEN_DEF) l = MAX_LEN_DEF;
      if (l != int'(len)) begin
        len = l;
        wipe();
      end
    endfunction

    function void note_beat(logic [2:0] op, bit mv, logic [IDX_W-1:0] row,
                            logic [IDX_W-1:0] col, logic [NL_W-1:0] nl);
      int      c;
      int      cut;
      int      slot;
      result_t r;
      c   = coef;
      cut = cutoff;
      r   = '0;
      case (op)
        OP_CHECK: begin
          if (!(c < cut && c > -cut) && mv) r.tabu_hit = tabu_map[row * N_DEF + col];
        end
        OP_ADD: begin
          if (c >= cut && mv) begin
            slot = pos % RING_DEPTH;
            if (ring_vld[slot]) tabu_map[ring_row[slot] * N_DEF + ring_col[slot]] = 1'b0;
            ring_vld[slot] = 1'b1;
            ring_row[slot] = row;
            ring_col[slot] = col;
            tabu_map[row * N_DEF + col] = 1'b1;
            pos = (len != 0) ? (pos + 1) % len : 0;
            r.stored = 1'b1;
          end
        end
        OP_GROW:   set_length(int'(len) + STEP_DEF);
        OP_SHRINK: set_length(int'(len) - STEP_DEF);
        OP_RESIZE: set_length(int'(nl));
        OP_CLEAR: begin
          wipe();
          len = MIN_LEN_DEF;
        end
        default: ;
      endcase
      r.length_now = len[LEN_OUT_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [OUT_DW-1:0] data);
      result_t got;
      result_t exp_r;
      got = data;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.tabu_hit !== exp_r.tabu_hit) begin
        $error("tabu_hit: expected %0d, actual %0d", exp_r.tabu_hit, got.tabu_hit);
        errors++;
      end
      if (got.stored !== exp_r.stored) begin
        $error("stored: expected %0d, actual %0d", exp_r.stored, got.stored);
        errors++;
      end
      if (got.length_now !== exp_r.length_now) begin
        $error("length_now: expected %0d, actual %0d", exp_r.length_now, got.length_now);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic [IN_UW-1:0]  in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [COEF_W-1:0] cfg_wdata;

  tabu_scoreboard sb;
  bit             hold_req;
  int             idle_cycles;
  int             burst_left;

  int coef_set [NUM_SETS] = '{256, 32767, -32768, 0, -300, 25, 26, -26, -25, 32767, -32767, 100};
  int cut_set  [NUM_SETS] = '{26, 0, 0, 0, 26, 26, 26, 26, 26, 32767, 32767, 32767};
  int ready_pcts [4]      = '{100, 75, 40, 10};

  tabu_pair_list uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic send_beat(logic [2:0] op, bit mv, logic [IDX_W-1:0] row,
                           logic [IDX_W-1:0] col, logic [NL_W-1:0] nl);
    in_data_t d;
    in_user_t u;
    d            = '0;
    d.row        = row;
    d.col        = col;
    d.new_length = nl;
    u.move_valid = mv;
    u.opcode     = opcode_t'(op);
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= u;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_beat(op, mv, row, col, nl);
    @(negedge clk);
  endtask

  task automatic write_regs(logic [COEF_W-1:0] coef_val, logic [CUT_W-1:0] cut_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_COEF;
    cfg_wdata <= coef_val;
    @(negedge clk);
    cfg_addr  <= CFG_CUTOFF;
    cfg_wdata <= {1'($urandom_range(0, 1)), cut_val};
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.coef   = coef_val;
    sb.cutoff = cut_val;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) sb.check_result(out_tdata);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready === 1'b1) || (out_tvalid === 1'b1 && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int pct;
    int span;
    out_tready = 1'b0;
    forever begin
      pct  = ready_pcts[$urandom_range(0, 3)];
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_req = 1'b0;
        end else begin
          out_tready <= ($urandom_range(0, 99) < pct);
        end
      end
    end
  end

  initial begin
    int               pick;
    bit               gaps_on;
    logic [2:0]       op;
    bit               mv;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [NL_W-1:0]  nl;
    sb          = new();
    idle_cycles = 0;
    burst_left  = 0;
    hold_req    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_we      = 1'b0;
    cfg_addr    = CFG_COEF;
    cfg_wdata   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    write_regs(16'sd256, 15'd26);
    send_beat(OP_CHECK,  1, 0,  0,  0);
    send_beat(OP_ADD,    1, 0,  0,  0);
    send_beat(OP_ADD,    1, 63, 63, 255);
    send_beat(OP_CHECK,  1, 63, 63, 0);
    send_beat(OP_CHECK,  0, 63, 63, 0);
    send_beat(OP_ADD,    0, 5,  5,  0);
    send_beat(OP_ADD,    1, 1,  1,  0);
    send_beat(OP_ADD,    1, 1,  1,  0);
    send_beat(OP_ADD,    1, 2,  3,  0);
    send_beat(OP_ADD,    1, 4,  5,  0);
    send_beat(OP_ADD,    1, 6,  7,  0);
    send_beat(OP_CHECK,  1, 1,  1,  0);
    send_beat(OP_SHRINK, 1, 0,  0,  0);
    send_beat(OP_CHECK,  1, 2,  3,  0);
    send_beat(OP_GROW,   1, 0,  0,  0);
    send_beat(OP_CHECK,  1, 2,  3,  0);
    send_beat(OP_RESIZE, 1, 0,  0,  255);
    send_beat(OP_ADD,    1, 10, 20, 0);
    send_beat(OP_RESIZE, 1, 0,  0,  40);
    send_beat(OP_CHECK,  1, 10, 20, 0);
    send_beat(OP_RESIZE, 1, 0,  0,  0);
    send_beat(OP_NOP6,   1, 63, 0,  128);
    send_beat(OP_NOP7,   0, 0,  63, 1);
    send_beat(OP_ADD,    1, 9,  9,  0);
    send_beat(OP_CLEAR,  1, 9,  9,  0);
    drain();

    for (int p = 0; p < NUM_SETS; p++) begin
      write_regs(16'(coef_set[p]), 15'(cut_set[p]));
      gaps_on = (p % 3 != 2);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 1 && k == 30) hold_req = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if (gaps_on) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
          end
        end
        burst_left--;
        pick = $urandom_range(0, 99);
        if (pick < 46)      op = OP_ADD;
        else if (pick < 86) op = OP_CHECK;
        else if (pick < 90) op = OP_GROW;
        else if (pick < 94) op = OP_SHRINK;
        else if (pick < 97) op = OP_RESIZE;
        else if (pick < 98) op = OP_CLEAR;
        else if (pick < 99) op = OP_NOP6;
        else                op = OP_NOP7;
        mv = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 9) < 7) begin
          row = IDX_W'($urandom_range(0, 7));
          col = IDX_W'($urandom_range(0, 7));
        end else begin
          row = IDX_W'($urandom_range(0, 63));
          col = IDX_W'($urandom_range(0, 63));
        end
        nl = NL_W'($urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom_range(0, 255));
        send_beat(op, mv, row, col, nl);
      end
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tpl_pkg.sv
src/tpl_ram.sv
src/tabu_pair_list.sv
sim/tb.sv
